FILE: sv/slfh_pkg.sv
// ----------------------------------------------------------------------------
// slfh_pkg: shared types and constants for the frame hunter
// Word layouts of both channels, configuration set, phase and code enums.
// ----------------------------------------------------------------------------
package slfh_pkg;

  // frame delimiters and limits
  localparam logic [7:0]  START_BYTE     = 8'h02;
  localparam logic [23:0] IDLE_MAX       = 24'hFFFFFF;
  localparam logic [16:0] TRAILER_BYTES  = 17'd2;
  localparam logic [16:0] FRAME_OVERHEAD = 17'd5;

  // configuration reset values
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd507;
  localparam logic [23:0] TIMEOUT_RST     = 24'd0;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_PAYLOAD = 1'b0,
    CFG_TIMEOUT     = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ROLE_START   = 3'd0,
    ROLE_LEN_HI  = 3'd1,
    ROLE_LEN_LO  = 3'd2,
    ROLE_PAYLOAD = 3'd3,
    ROLE_END     = 3'd4,
    ROLE_CHECK   = 3'd5
  } role_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_BODY   = 2'd3
  } phase_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [2:0]  role;
    logic        last;
    logic [1:0]  status;
    logic [16:0] total_length;
  } out_word_t;

  typedef struct packed {
    logic [15:0] max_payload;
    logic [23:0] timeout_ticks;
  } cfg_t;

endpackage

FILE: sv/slfh_in_stage.sv
// ----------------------------------------------------------------------------
// slfh_in_stage: input register
// Holds one incoming word; refills in the same cycle the parser takes it.
// ----------------------------------------------------------------------------
module slfh_in_stage import slfh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  logic     pop_i,
  output logic     valid_o,
  output in_word_t word_o
);

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     load;

  // free when empty or being drained this cycle
  assign in_ready_o = !valid_q || pop_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= in_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: sv/slfh_parser.sv
// ----------------------------------------------------------------------------
// slfh_parser: frame phase tracker
// Walks start, length, body and trailer bytes, counts idle ticks and builds
// the result word for each consumed input word.
// ----------------------------------------------------------------------------
module slfh_parser import slfh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_word_t  word_i,
  input  cfg_t      cfg_i,
  output logic      res_valid_o,
  output out_word_t res_word_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] flen_q, flen_d;
  logic [16:0] left_q, left_d;
  logic [23:0] idle_q, idle_d;

  logic [15:0] len_full;
  logic        too_long;
  logic        timeout_hit;
  logic        is_tick;

  // shared decode
  assign is_tick     = (word_i.opcode == OP_TICK);
  assign len_full    = {flen_q[15:8], word_i.rx_byte};
  assign too_long    = (len_full > cfg_i.max_payload);
  assign timeout_hit = (cfg_i.timeout_ticks != 24'd0) && (idle_q >= cfg_i.timeout_ticks);

  // next state
  always_comb begin
    phase_d = phase_q;
    flen_d  = flen_q;
    left_d  = left_q;
    idle_d  = idle_q;
    if (fire_i) begin
      if (is_tick) begin
        if (phase_q != PH_HUNT) begin
          if (timeout_hit) begin
            phase_d = PH_HUNT;
            flen_d  = 16'd0;
            left_d  = 17'd0;
            idle_d  = 24'd0;
          end else if (idle_q != IDLE_MAX) begin
            idle_d = idle_q + 24'd1;
          end
        end
      end else begin
        case (phase_q)
          PH_HUNT: begin
            if (word_i.rx_byte == START_BYTE) begin
              phase_d = PH_LEN_HI;
              idle_d  = 24'd0;
            end
          end
          PH_LEN_HI: begin
            flen_d  = {word_i.rx_byte, 8'h00};
            phase_d = PH_LEN_LO;
            idle_d  = 24'd0;
          end
          PH_LEN_LO: begin
            flen_d = len_full;
            idle_d = 24'd0;
            if (too_long) begin
              phase_d = PH_HUNT;
              left_d  = 17'd0;
            end else begin
              phase_d = PH_BODY;
              left_d  = {1'b0, len_full} + TRAILER_BYTES;
            end
          end
          PH_BODY: begin
            idle_d = 24'd0;
            if (left_q > TRAILER_BYTES) begin
              left_d = left_q - 17'd1;
            end else if (left_q == TRAILER_BYTES) begin
              left_d = 17'd1;
            end else begin
              left_d  = 17'd0;
              phase_d = PH_HUNT;
            end
          end
          default: begin
            phase_d = PH_HUNT;
          end
        endcase
      end
    end
  end

  // result word
  always_comb begin
    res_valid_o             = 1'b0;
    res_word_o.data         = word_i.rx_byte;
    res_word_o.role         = ROLE_START;
    res_word_o.last         = 1'b0;
    res_word_o.status       = ST_OK;
    res_word_o.total_length = 17'd0;
    if (is_tick) begin
      res_word_o.data = 8'h00;
      if ((phase_q != PH_HUNT) && timeout_hit) begin
        res_valid_o       = 1'b1;
        res_word_o.last   = 1'b1;
        res_word_o.status = ST_TIMEOUT;
      end
    end else begin
      case (phase_q)
        PH_HUNT: begin
          res_valid_o = (word_i.rx_byte == START_BYTE);
        end
        PH_LEN_HI: begin
          res_valid_o     = 1'b1;
          res_word_o.role = ROLE_LEN_HI;
        end
        PH_LEN_LO: begin
          res_valid_o     = 1'b1;
          res_word_o.role = ROLE_LEN_LO;
          if (too_long) begin
            res_word_o.last   = 1'b1;
            res_word_o.status = ST_TOO_LONG;
          end
        end
        PH_BODY: begin
          res_valid_o = 1'b1;
          if (left_q > TRAILER_BYTES) begin
            res_word_o.role = ROLE_PAYLOAD;
          end else if (left_q == TRAILER_BYTES) begin
            res_word_o.role = ROLE_END;
          end else begin
            res_word_o.role         = ROLE_CHECK;
            res_word_o.last         = 1'b1;
            res_word_o.total_length = {1'b0, flen_q} + FRAME_OVERHEAD;
          end
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      flen_q  <= 16'd0;
      left_q  <= 17'd0;
      idle_q  <= 24'd0;
    end else begin
      phase_q <= phase_d;
      flen_q  <= flen_d;
      left_q  <= left_d;
      idle_q  <= idle_d;
    end
  end

endmodule

FILE: sv/slfh_out_stage.sv
// ----------------------------------------------------------------------------
// slfh_out_stage: result register
// Holds one result word until taken; reports room for the next one.
// ----------------------------------------------------------------------------
module slfh_out_stage import slfh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_word_t word_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic      valid_q, valid_d;
  out_word_t word_q;

  // room when empty or the held word leaves this cycle
  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

FILE: sv/stx_length_frame_hunter_core.sv
// ----------------------------------------------------------------------------
// stx_length_frame_hunter_core: STX / length / end mark / check byte deframer
// Hunts for the start byte, tags every frame byte with its role, closes the
// frame with its total length and aborts on idle timeout or oversize length.
//
//   port group   direction  handshake              payload
//   in           in         in_valid_i/in_ready_o  in_word_i  (opcode, rx_byte)
//   out          out        out_valid_o/out_ready_i out_word_o (data .. total_length)
//   cfg          in         cfg_we_i               cfg_index_i, cfg_value_i
//
// One word per cycle while the result register has room; an accepted word that
// yields a result passes from the input register through the parser into the result register.
// Reset returns the parser to hunting and restores both configuration values.
// A stalled result register holds the parser and then the input register; the
// input side takes a word whenever the input register drains in that cycle.
// ----------------------------------------------------------------------------
module stx_length_frame_hunter_core import slfh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_value_i
);

  cfg_t      cfg_q, cfg_d;
  logic      stage_valid;
  in_word_t  stage_word;
  logic      out_space;
  logic      fire;
  logic      res_valid;
  out_word_t res_word;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_PAYLOAD: cfg_d.max_payload   = cfg_value_i[15:0];
        CFG_TIMEOUT:     cfg_d.timeout_ticks = cfg_value_i[23:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload   <= MAX_PAYLOAD_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // parser consumes a held word whenever the result register has room
  assign fire = stage_valid && out_space;

  slfh_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .pop_i      (fire),
    .valid_o    (stage_valid),
    .word_o     (stage_word)
  );

  slfh_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .word_i      (stage_word),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_word_o  (res_word)
  );

  slfh_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && res_valid),
    .word_i      (res_word),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

`ifndef NO_ASSERTIONS
  // a full input register facing a stalled result register takes nothing
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while pipeline stalled");

  // any abort status closes the frame
  a_abort_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status != ST_OK)) |-> out_word_o.last)
    else $error("abort word without last");

  // a clean frame ends only on its check byte
  a_ok_last_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.last && (out_word_o.status == ST_OK))
      |-> (out_word_o.role == ROLE_CHECK))
    else $error("clean frame closed on wrong role");

  // total length only carried by the check byte
  a_total_on_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.role != ROLE_CHECK)) |-> (out_word_o.total_length == 17'd0))
    else $error("total length on non-check word");
`endif

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for stx_length_frame_hunter_core
// Sends hunt noise, well-formed frames with random content, oversize headers,
// truncated frames and idle ticks under several register settings. A frame
// tracker predicts every result word and checks the output stream field by
// field, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb import slfh_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // predicted deframer state and the result words still owed
  class frame_tracker;
    logic [15:0] max_payload;
    logic [23:0] timeout_ticks;
    phase_e      phase;
    logic [15:0] frame_len;
    logic [16:0] bytes_left;
    logic [23:0] idle_count;
    out_word_t   owed_words[$];
    int unsigned mismatches;
    int unsigned busy_words;

    function new();
      max_payload   = MAX_PAYLOAD_RST;
      timeout_ticks = TIMEOUT_RST;
      phase         = PH_HUNT;
      frame_len     = '0;
      bytes_left    = '0;
      idle_count    = '0;
      mismatches    = 0;
      busy_words    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_MAX_PAYLOAD: max_payload = value[15:0];
        CFG_TIMEOUT:     timeout_ticks = value[23:0];
        default: ;
      endcase
    endfunction

    function void owe(logic [7:0] data, role_e role, logic last, status_e status,
                      logic [16:0] total);
      out_word_t w;
      w.data         = data;
      w.role         = role;
      w.last         = last;
      w.status       = status;
      w.total_length = total;
      owed_words.push_back(w);
    endfunction

    // advance the predicted state by one accepted input word
    function void note_word(in_word_t w);
      if (w.opcode == OP_TICK) begin
        if (phase == PH_HUNT) return;
        busy_words++;
        if (timeout_ticks != 0 && idle_count >= timeout_ticks) begin
          phase      = PH_HUNT;
          frame_len  = '0;
          bytes_left = '0;
          idle_count = '0;
          owe(8'h00, ROLE_START, 1'b1, ST_TIMEOUT, '0);
        end else if (idle_count != IDLE_MAX) begin
          idle_count++;
        end
        return;
      end
      if (phase == PH_HUNT && w.rx_byte != START_BYTE) return;
      busy_words++;
      idle_count = '0;
      case (phase)
        PH_HUNT: begin
          phase = PH_LEN_HI;
          owe(w.rx_byte, ROLE_START, 1'b0, ST_OK, '0);
        end
        PH_LEN_HI: begin
          frame_len = {w.rx_byte, 8'h00};
          phase     = PH_LEN_LO;
          owe(w.rx_byte, ROLE_LEN_HI, 1'b0, ST_OK, '0);
        end
        PH_LEN_LO: begin
          frame_len = {frame_len[15:8], w.rx_byte};
          if (frame_len > max_payload) begin
            phase      = PH_HUNT;
            bytes_left = '0;
            owe(w.rx_byte, ROLE_LEN_LO, 1'b1, ST_TOO_LONG, '0);
          end else begin
            bytes_left = {1'b0, frame_len} + TRAILER_BYTES;
            phase      = PH_BODY;
            owe(w.rx_byte, ROLE_LEN_LO, 1'b0, ST_OK, '0);
          end
        end
        default: begin
          if (bytes_left > TRAILER_BYTES) begin
            bytes_left--;
            owe(w.rx_byte, ROLE_PAYLOAD, 1'b0, ST_OK, '0);
          end else if (bytes_left == TRAILER_BYTES) begin
            bytes_left = 17'd1;
            owe(w.rx_byte, ROLE_END, 1'b0, ST_OK, '0);
          end else begin
            bytes_left = '0;
            phase      = PH_HUNT;
            owe(w.rx_byte, ROLE_CHECK, 1'b1, ST_OK, {1'b0, frame_len} + FRAME_OVERHEAD);
          end
        end
      endcase
    endfunction

    // compare one output word with the oldest owed word
    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (owed_words.size() == 0) begin
        $error("unexpected result word: data %0d role %0d", got.data, got.role);
        mismatches++;
        return;
      end
      exp_w = owed_words.pop_front();
      if (got.data !== exp_w.data) begin
        $error("data: expected %0d, got %0d", exp_w.data, got.data);
        mismatches++;
      end
      if (got.role !== exp_w.role) begin
        $error("role: expected %0d, got %0d", exp_w.role, got.role);
        mismatches++;
      end
      if (got.last !== exp_w.last) begin
        $error("last: expected %0d, got %0d", exp_w.last, got.last);
        mismatches++;
      end
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, got %0d", exp_w.status, got.status);
        mismatches++;
      end
      if (got.total_length !== exp_w.total_length) begin
        $error("total_length: expected %0d, got %0d", exp_w.total_length,
               got.total_length);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_value = '0;
  bit                    calm = 1'b0;
  int unsigned           cycles = 0;

  frame_tracker tracker = new();

  stx_length_frame_hunter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_value_i (cfg_value)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one; none in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one input word and wait for it to be taken
  task automatic send_word(in_word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready);
    tracker.note_word(w);
  endtask

  task automatic send_byte(logic [7:0] b);
    in_word_t w;
    w.opcode  = OP_BYTE;
    w.rx_byte = b;
    send_word(w);
  endtask

  task automatic send_tick();
    in_word_t w;
    w.opcode  = OP_TICK;
    w.rx_byte = 8'($urandom_range(0, 255));
    send_word(w);
  endtask

  // stop sending and wait until every owed word has come out and the pipe is empty
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (tracker.owed_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_value <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  // one frame of the given payload length; oversize lengths send the header only,
  // a cut frame stops early and is then timed out
  task automatic send_frame(int unsigned len, bit cut);
    logic [7:0]  frame_bytes[$];
    int unsigned stop;
    int unsigned tmax;
    frame_bytes = {START_BYTE, len[15:8], len[7:0]};
    if (len <= tracker.max_payload) begin
      repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    stop = cut ? $urandom_range(1, frame_bytes.size() - 1) : frame_bytes.size();
    tmax = (tracker.timeout_ticks == 0 || tracker.timeout_ticks > 30) ? 3 :
           tracker.timeout_ticks;
    for (int unsigned i = 0; i < stop; i++) begin
      // idle ticks up to the timeout, never past it
      if (i > 0 && $urandom_range(0, 99) < 8) repeat ($urandom_range(1, tmax)) send_tick();
      send_byte(frame_bytes[i]);
    end
    if (cut) repeat (tracker.timeout_ticks + 1) send_tick();
  endtask

  // result side: random stalls, sampled at the rising edge
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) tracker.check_word(out_word);
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk_i) cycles++;
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    logic [15:0] mp;
    logic [23:0] tmo;
    int unsigned busy_target;
    int unsigned phase_target;
    int unsigned len;
    int unsigned r;
    logic [7:0]  noise;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: reset settings, hunt noise, zero payload, mid-frame tick, oversize
    send_tick();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(START_BYTE); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h03); send_byte(8'hA5);
    send_byte(START_BYTE); send_byte(8'h00); send_byte(8'h01);
    send_tick();
    send_byte(8'hFF); send_byte(8'h03); send_byte(8'h00);
    send_byte(START_BYTE); send_byte(8'hFF); send_byte(8'hFF);

    // directed: no payload allowed, one idle tick allowed
    settle();
    write_reg(CFG_MAX_PAYLOAD, '0);
    write_reg(CFG_TIMEOUT, 24'd1);
    send_byte(START_BYTE); send_byte(8'h00); send_byte(8'h00);
    send_tick(); send_tick();
    send_byte(START_BYTE); send_byte(8'h00); send_byte(8'h01);

    // long frame, then a short one, at the widest settings, with no handshake gaps
    settle();
    calm = 1'b1;
    write_reg(CFG_MAX_PAYLOAD, 24'hFFFF);
    write_reg(CFG_TIMEOUT, 24'hFFFFFF);
    send_frame(200, 1'b0);
    send_frame(3, 1'b0);
    settle();
    calm = 1'b0;

    // random phases, each under its own settings
    busy_target = tracker.busy_words + 1200;
    while (tracker.busy_words < busy_target) begin
      settle();
      case ($urandom_range(0, 3))
        0:       mp = '0;
        1:       mp = 16'hFFFF;
        2:       mp = 16'($urandom_range(1, 24));
        default: mp = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 3))
        0:       tmo = '0;
        1:       tmo = 24'($urandom_range(1, 4));
        2:       tmo = 24'($urandom_range(5, 30));
        default: tmo = 24'($urandom_range(0, 24'hFFFFFF));
      endcase
      write_reg(CFG_MAX_PAYLOAD, {8'h00, mp});
      write_reg(CFG_TIMEOUT, tmo);
      calm = ($urandom_range(0, 4) == 0);
      phase_target = tracker.busy_words + $urandom_range(100, 250);
      while (tracker.busy_words < phase_target) begin
        // noise and ticks while hunting
        repeat ($urandom_range(0, 2)) begin
          noise = 8'($urandom_range(0, 255));
          if (noise == START_BYTE) noise = ~START_BYTE;
          send_byte(noise);
        end
        if ($urandom_range(0, 3) == 0) send_tick();
        r = $urandom_range(0, 99);
        if (r < 10 && mp != 16'hFFFF) begin
          send_frame($urandom_range(mp + 1, 65535), 1'b0);
        end else begin
          len = $urandom_range(0, (mp < 24) ? mp : 24);
          send_frame(len, (r >= 88 && tmo != 0 && tmo <= 30));
        end
      end
    end

    // drain and finish
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (tracker.owed_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.owed_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
